[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, held off while in reset.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a property at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/rlfc_pkg.sv]
// ----------------------------------------------------------------------------
// rlfc_pkg
// Types, codes and byte constants shared by the line and frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfc_pkg;

	localparam int MSG_DEPTH_DEF = 64;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_OPEN  = 8'h24;
	localparam logic [7:0] CH_CLOSE = 8'h23;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_LINE  = 2'd1,
		CMD_FRAME = 2'd2,
		CMD_IDLE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_FRAME = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_RECV = 2'd0,
		ST_READ = 2'd1,
		ST_SEND = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic msg_done;
		logic last_byte;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

[src/rlfc_ctrl.sv]
// ----------------------------------------------------------------------------
// rlfc_ctrl
// Sequencer: receive bytes, then read out a completed message byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlfc_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  rlfc_pkg::dp_status_t    status,
	output rlfc_pkg::ctrl_cmd_t     cmd
);

	rlfc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlfc_pkg::ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlfc_pkg::ST_RECV: begin
				if (s_tvalid && status.msg_done) begin
					state_d = rlfc_pkg::ST_READ;
				end
			end
			rlfc_pkg::ST_READ: begin
				state_d = rlfc_pkg::ST_SEND;
			end
			rlfc_pkg::ST_SEND: begin
				if (status.out_free) begin
					state_d = status.last_byte ? rlfc_pkg::ST_RECV : rlfc_pkg::ST_READ;
				end
			end
			default: begin
				state_d = rlfc_pkg::ST_RECV;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			rlfc_pkg::ST_RECV: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			rlfc_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			rlfc_pkg::ST_SEND: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// A message that completes must go straight to the read-out.
	`ASSERT_RST(a_done_starts_read,
		(cmd.accept && status.msg_done) |=> (state_q == rlfc_pkg::ST_READ),
		"completed message did not start read-out")
	// Each read is followed by a send step.
	`ASSERT_RST(a_read_then_send,
		cmd.rd_en |=> (state_q == rlfc_pkg::ST_SEND),
		"read not followed by send")

endmodule

`default_nettype wire

[src/rlfc_dp.sv]
// ----------------------------------------------------------------------------
// rlfc_dp
// Mode tracking, message store, read pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlfc_dp #(
	parameter int MSG_DEPTH = rlfc_pkg::MSG_DEPTH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [1:0]              s_tuser,
	input  wire  [7:0]              s_tdata,
	output logic                    m_tvalid,
	input  wire                     m_tready,
	output logic [7:0]              m_tdata,
	output logic [2:0]              m_tuser,
	output logic                    m_tlast,
	input  rlfc_pkg::ctrl_cmd_t     cmd,
	output rlfc_pkg::dp_status_t    status
);

	localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CW = $clog2(MSG_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(MSG_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [7:0]          mem [MSG_DEPTH];

	rlfc_pkg::mode_t     mode_q, mode_d;
	logic                cr_q, cr_d;
	logic                inside_q, inside_d;
	logic                ovf_q, ovf_d;
	logic [CW-1:0]       fill_q, fill_d;
	logic                wr_en;

	logic [CW-1:0]       emit_cnt_q;
	logic                emit_kind_q;
	logic                emit_trunc_q;
	logic [CW-1:0]       rd_ptr_q;
	logic [7:0]          rd_data_q;

	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic [2:0]          out_user_q;
	logic                out_last_q;

	rlfc_pkg::cmd_t      in_cmd;
	logic [7:0]          b;
	logic                full;
	logic                done;
	logic                emit_empty;
	logic                last_byte;

	assign in_cmd     = rlfc_pkg::cmd_t'(s_tuser);
	assign b          = s_tdata;
	assign full       = (fill_q == DEPTH_C);
	assign emit_empty = (emit_cnt_q == '0);
	assign last_byte  = emit_empty || ((rd_ptr_q + ONE_C) == emit_cnt_q);

	assign done = (in_cmd == rlfc_pkg::CMD_DATA) && (
		((mode_q == rlfc_pkg::MODE_LINE) && cr_q && (b == rlfc_pkg::CH_LF)) ||
		((mode_q == rlfc_pkg::MODE_FRAME) && inside_q && (b == rlfc_pkg::CH_CLOSE)));

	assign status.msg_done  = done;
	assign status.last_byte = last_byte;
	assign status.out_free  = !out_valid_q || m_tready;

	// Next receive state for one accepted transaction.
	always_comb begin
		mode_d   = mode_q;
		cr_d     = cr_q;
		inside_d = inside_q;
		ovf_d    = ovf_q;
		fill_d   = fill_q;
		wr_en    = 1'b0;
		if (cmd.accept) begin
			if (in_cmd != rlfc_pkg::CMD_DATA) begin
				unique case (in_cmd)
					rlfc_pkg::CMD_LINE:  mode_d = rlfc_pkg::MODE_LINE;
					rlfc_pkg::CMD_FRAME: mode_d = rlfc_pkg::MODE_FRAME;
					default:             mode_d = rlfc_pkg::MODE_IDLE;
				endcase
				cr_d     = 1'b0;
				inside_d = 1'b0;
				ovf_d    = 1'b0;
				fill_d   = '0;
			end else begin
				unique case (mode_q)
					rlfc_pkg::MODE_LINE: begin
						if (cr_q && (b == rlfc_pkg::CH_LF)) begin
							mode_d   = rlfc_pkg::MODE_IDLE;
							cr_d     = 1'b0;
							inside_d = 1'b0;
							ovf_d    = 1'b0;
							fill_d   = '0;
						end else begin
							if (!full) begin
								wr_en  = 1'b1;
								fill_d = fill_q + ONE_C;
							end else begin
								ovf_d = 1'b1;
							end
							if (b == rlfc_pkg::CH_CR) begin
								cr_d = 1'b1;
							end
						end
					end
					rlfc_pkg::MODE_FRAME: begin
						priority if (!inside_q) begin
							if (b == rlfc_pkg::CH_OPEN) begin
								inside_d = 1'b1;
								fill_d   = '0;
							end
						end else if (b == rlfc_pkg::CH_CLOSE || b == rlfc_pkg::CH_OPEN) begin
							inside_d = 1'b0;
							fill_d   = '0;
						end else if (!full) begin
							wr_en  = 1'b1;
							fill_d = fill_q + ONE_C;
						end else begin
							inside_d = 1'b0;
							fill_d   = '0;
						end
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rlfc_pkg::MODE_IDLE;
			cr_q        <= 1'b0;
			inside_q    <= 1'b0;
			ovf_q       <= 1'b0;
			fill_q      <= '0;
			emit_cnt_q  <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			cr_q     <= cr_d;
			inside_q <= inside_d;
			ovf_q    <= ovf_d;
			fill_q   <= fill_d;
			if (cmd.accept && done) begin
				emit_cnt_q <= fill_q;
				rd_ptr_q   <= '0;
			end else if (cmd.load_out) begin
				rd_ptr_q <= rd_ptr_q + ONE_C;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= b;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_ptr_q[AW-1:0]];
		end
		if (cmd.accept && done) begin
			emit_kind_q  <= (mode_q == rlfc_pkg::MODE_FRAME);
			emit_trunc_q <= (mode_q == rlfc_pkg::MODE_LINE) && ovf_q;
		end
		if (cmd.load_out) begin
			out_byte_q <= emit_empty ? 8'h00 : rd_data_q;
			out_user_q <= {emit_trunc_q, !emit_empty, emit_kind_q};
			out_last_q <= last_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	`ASSERT_RST(a_fill_in_range, fill_q <= DEPTH_C, "fill count beyond store depth")
	`ASSERT_RST(a_no_overwrite, !(cmd.load_out && out_valid_q && !m_tready),
		"output register overwritten while stalled")
	`ASSERT_RST(a_read_in_range, cmd.rd_en |-> (emit_empty || rd_ptr_q < emit_cnt_q),
		"read pointer past message end")

endmodule

`default_nettype wire

[src/reply_line_and_frame_capture.sv]
// ----------------------------------------------------------------------------
// reply_line_and_frame_capture
// Deframer for serial bytes: captures CR/LF-terminated reply lines and
// dollar-hash delimited frames, then streams each message out byte by byte.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while receiving; a transaction
//   that completes a message stalls input while its bytes are sent (one zero byte
//   for an empty message), each by a registered store read and a send step.
// Read-out: the first byte passes the read state, store read and output register.
// Reset: arst_n clears mode, progress, read pointer and output valid at once;
//   the message store has no reset and its data is used only below the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_line_and_frame_capture #(
	parameter int MSG_DEPTH = rlfc_pkg::MSG_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] rx_byte
	input  wire  [1:0] s_tuser,   // [1:0] command
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] message_byte
	output logic [2:0] m_tuser,   // [0] message_kind, [1] byte_valid, [2] truncated
	output logic       m_tlast    // last byte of the message
);

	// Controller drives the datapath with commands and reads back status.
	rlfc_pkg::ctrl_cmd_t  cmd;
	rlfc_pkg::dp_status_t status;

	// Sequence receive and read-out; hold input off while a message drains.
	rlfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Track mode and delimiters, store bytes, and register each result.
	// The output register lets a new transaction in while the final byte
	// of the previous message still waits on m_tready.
	rlfc_dp #(
		.MSG_DEPTH (MSG_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

`default_nettype wire
